// ===== design/wpia_pkg.sv =====
package wpia_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;
  localparam int WID_W  = 7;

  typedef logic [3:0] op_t;
  localparam op_t OP_ADD = 4'd0;
  localparam op_t OP_SUB = 4'd1;
  localparam op_t OP_MUL = 4'd2;
  localparam op_t OP_DIV = 4'd3;
  localparam op_t OP_MOD = 4'd4;
  localparam op_t OP_SHL = 4'd5;
  localparam op_t OP_SHR = 4'd6;
  localparam op_t OP_AND = 4'd7;
  localparam op_t OP_XOR = 4'd8;
  localparam op_t OP_OR  = 4'd9;
  localparam op_t OP_NOT = 4'd10;
  localparam op_t OP_NEG = 4'd11;
  localparam op_t OP_CMP = 4'd12;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  // per item fields that ride along the divider chain
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] r;
    logic [1:0]        st;
    logic [1:0]        cmp;
    logic              nx;
    logic              ny;
  } item_t;

  // restoring divider working state
  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] d;
  } div_t;

endpackage

// ===== design/wpia_div_step.sv =====
module wpia_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  wpia_pkg::item_t in_item,
  input  wpia_pkg::div_t  in_div,
  output logic           out_vld,
  output wpia_pkg::item_t out_item,
  output wpia_pkg::div_t  out_div
);
  import wpia_pkg::*;

  logic [WORD_W:0]   t;
  logic [WORD_W:0]   diff;
  logic              ge;
  div_t              div_next;

  // one quotient bit per stage
  always_comb begin
    t    = {in_div.rem, in_div.q[WORD_W-1]};
    diff = t - {1'b0, in_div.d};
    ge   = (t >= {1'b0, in_div.d});
    div_next.rem = ge ? diff[WORD_W-1:0] : t[WORD_W-1:0];
    div_next.q   = {in_div.q[WORD_W-2:0], ge};
    div_next.d   = in_div.d;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= in_item;
      out_div  <= div_next;
    end
  end

endmodule

// ===== design/width_param_integer_alu_top.sv =====
// Integer ALU with an operand width of 1 to MAX_WIDTH bits per transaction and status flags.
// Fully pipelined: one transaction is accepted every cycle unless the pipeline holds, and
// each result passes MAX_WIDTH + 4 registers on its way: three front
// stages (masking; simple ops and four 32x32 partial products; product sum and divider
// load), MAX_WIDTH restoring divider stages, one bit each, and the output register.
// The whole pipeline holds when a result waits and m_tready is low; s_tready follows
// that same hold.
module width_param_integer_alu_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[3:0], width[10:4], is_signed[11], lhs_value[75:12], rhs_value[139:76]
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_value[63:0], status[65:64], compare[67:66]
  output logic [71:0]  m_tdata
);
  import wpia_pkg::*;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: clamp width, mask operands
  logic [WID_W-1:0]  w_in;
  logic [WID_W-1:0]  w_cl;
  logic [WORD_W-1:0] m_in;
  logic              v1;
  op_t               op1;
  logic [WID_W-1:0]  w1;
  logic              sgn1;
  logic [WORD_W-1:0] m1, x1, y1;

  always_comb begin
    w_in = s_tdata[10:4];
    if (w_in == '0) begin
      w_cl = WID_W'(1);
    end else if (w_in > WID_W'(MAX_WIDTH)) begin
      w_cl = WID_W'(MAX_WIDTH);
    end else begin
      w_cl = w_in;
    end
    m_in = ~({WORD_W{1'b1}} << w_cl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= s_tdata[3:0];
      w1   <= w_cl;
      sgn1 <= s_tdata[11];
      m1   <= m_in;
      x1   <= s_tdata[75:12] & m_in;
      y1   <= s_tdata[139:76] & m_in;
    end
  end

  // stage 2: simple ops, magnitudes, multiplier partial products
  item_t             it2_next;
  logic [WORD_W-1:0] r_add, r_sub, r_shl, sb, ca, cb, ux, uy;
  logic              big_shift;
  logic              v2;
  item_t             it2;
  logic [WORD_W-1:0] y2, ux2, uy2;
  logic [WORD_W-1:0] pp0, pp1, pp2, pp3;

  always_comb begin
    r_add     = (x1 + y1) & m1;
    r_sub     = (x1 - y1) & m1;
    big_shift = (y1 >= WORD_W'(w1));
    r_shl     = (x1 << y1[5:0]) & m1;
    sb        = sgn1 ? (WORD_W'(1) << (w1 - WID_W'(1))) : '0;
    ca        = x1 ^ sb;
    cb        = y1 ^ sb;
    it2_next.op  = op1;
    it2_next.m   = m1;
    it2_next.r   = x1;
    it2_next.st  = ST_OK;
    it2_next.cmp = CMP_EQ;
    it2_next.nx  = sgn1 && ((x1 >> (w1 - WID_W'(1))) & WORD_W'(1)) != '0;
    it2_next.ny  = sgn1 && ((y1 >> (w1 - WID_W'(1))) & WORD_W'(1)) != '0;
    ux = it2_next.nx ? ((-x1) & m1) : x1;
    uy = it2_next.ny ? ((-y1) & m1) : y1;
    case (op1)
      OP_ADD: begin
        it2_next.r = r_add;
        if (r_add < x1) it2_next.st = ST_OVER;
      end
      OP_SUB: begin
        it2_next.r = r_sub;
        if (r_sub > x1) it2_next.st = ST_UNDER;
      end
      OP_DIV, OP_MOD: begin
        if (y1 == '0) it2_next.st = ST_DIVZ;
      end
      OP_SHL: begin
        if (big_shift) begin
          it2_next.r = '0;
          if (x1 != '0) it2_next.st = ST_OVER;
        end else begin
          it2_next.r = r_shl;
          if ((x1 & ~(m1 >> y1[5:0])) != '0) it2_next.st = ST_OVER;
        end
      end
      OP_SHR: begin
        if (big_shift) begin
          it2_next.r = '0;
          if (x1 != '0) it2_next.st = ST_UNDER;
        end else begin
          it2_next.r = x1 >> y1[5:0];
          if ((x1 & ~({WORD_W{1'b1}} << y1[5:0])) != '0) it2_next.st = ST_UNDER;
        end
      end
      OP_AND: it2_next.r = x1 & y1;
      OP_XOR: it2_next.r = x1 ^ y1;
      OP_OR:  it2_next.r = x1 | y1;
      OP_NOT: it2_next.r = (~x1) & m1;
      OP_NEG: it2_next.r = (-x1) & m1;
      OP_CMP: begin
        if (ca == cb) begin
          it2_next.cmp = CMP_EQ;
        end else if (ca > cb) begin
          it2_next.cmp = CMP_GT;
        end else begin
          it2_next.cmp = CMP_LT;
        end
      end
      default: it2_next.r = x1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2 <= it2_next;
      y2  <= y1;
      ux2 <= ux;
      uy2 <= uy;
      pp0 <= x1[HALF_W-1:0]      * y1[HALF_W-1:0];
      pp1 <= x1[WORD_W-1:HALF_W] * y1[HALF_W-1:0];
      pp2 <= x1[HALF_W-1:0]      * y1[WORD_W-1:HALF_W];
      pp3 <= x1[WORD_W-1:HALF_W] * y1[WORD_W-1:HALF_W];
    end
  end

  // stage 3: sum partial products, merge multiply result, load divider
  logic [2*WORD_W-1:0] prod;
  item_t               it3_next;
  div_t                d3_next;
  logic                v3;
  item_t               it3;
  div_t                d3;

  always_comb begin
    prod = {{WORD_W{1'b0}}, pp0}
         + ({{WORD_W{1'b0}}, pp1} << HALF_W)
         + ({{WORD_W{1'b0}}, pp2} << HALF_W)
         + ({pp3, {WORD_W{1'b0}}});
    it3_next = it2;
    if (it2.op == OP_MUL) begin
      it3_next.r = prod[WORD_W-1:0] & it2.m;
      if ((prod & ~{{WORD_W{1'b0}}, it2.m}) != '0) it3_next.st = ST_OVER;
    end
    d3_next.rem = '0;
    d3_next.q   = ux2 << (WORD_W - MAX_WIDTH);
    d3_next.d   = (y2 == '0) ? WORD_W'(1) : uy2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it3 <= it3_next;
      d3  <= d3_next;
    end
  end

  // divider chain
  logic  vd  [MAX_WIDTH+1];
  item_t itd [MAX_WIDTH+1];
  div_t  dd  [MAX_WIDTH+1];

  assign vd[0]  = v3;
  assign itd[0] = it3;
  assign dd[0]  = d3;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_div
    wpia_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (vd[i]),
      .in_item  (itd[i]),
      .in_div   (dd[i]),
      .out_vld  (vd[i+1]),
      .out_item (itd[i+1]),
      .out_div  (dd[i+1])
    );
  end

  // final sign fix for div and mod
  item_t             itf;
  div_t              df;
  logic [WORD_W-1:0] r_fin;

  always_comb begin
    itf   = itd[MAX_WIDTH];
    df    = dd[MAX_WIDTH];
    r_fin = itf.r;
    if (itf.st != ST_DIVZ) begin
      if (itf.op == OP_DIV) begin
        r_fin = ((itf.nx != itf.ny) ? -df.q : df.q) & itf.m;
      end else if (itf.op == OP_MOD) begin
        r_fin = (itf.nx ? -df.rem : df.rem) & itf.m;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vd[MAX_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'b0, itf.cmp, itf.st, r_fin};
    end
  end

  // a finished item reaches the output
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    adv && vd[MAX_WIDTH] |=> m_tvalid)
    else $error("finished item lost before output");

  // a held pipeline keeps its last divider stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vd[MAX_WIDTH]) && $stable(dd[MAX_WIDTH]))
    else $error("divider chain moved during stall");

  // compare results other than equal never carry an error status
  a_cmp_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[67:66] != CMP_EQ |-> m_tdata[65:64] == ST_OK)
    else $error("compare result with nonzero status");

endmodule

// ===== dv/wpia_result_checker.sv =====
`timescale 1ns / 100ps

module wpia_result_checker
  import wpia_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  output int           fail_count,
  output int           pending,
  output int           result_count
);

  typedef struct {
    logic [63:0] res;
    logic [1:0]  st;
    logic [1:0]  cmp;
  } alu_out_t;

  alu_out_t predicted_q[$];

  // golden behavior of one alu transaction
  function automatic alu_out_t alu_predict(op_t op, logic [6:0] w_in, logic sgn,
                                           logic [63:0] lhs, logic [63:0] rhs);
    alu_out_t    o;
    int unsigned w;
    logic [63:0] m, x, y, ux, uy, sb, a, b;
    logic [127:0] full;
    logic        nx, ny;
    w = 32'(w_in);
    if (w == 0) w = 1;
    if (w > 64) w = 64;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    x = lhs & m;
    y = rhs & m;
    o.res = x;
    o.st = ST_OK;
    o.cmp = CMP_EQ;
    case (op)
      OP_ADD: begin
        o.res = (x + y) & m;
        if (o.res < x) o.st = ST_OVER;
      end
      OP_SUB: begin
        o.res = (x - y) & m;
        if (o.res > x) o.st = ST_UNDER;
      end
      OP_MUL: begin
        full = {64'd0, x} * {64'd0, y};
        o.res = full[63:0] & m;
        if (full > {64'd0, m}) o.st = ST_OVER;
      end
      OP_DIV, OP_MOD: begin
        if (y == 0) begin
          o.st = ST_DIVZ;
        end else begin
          nx = sgn && x[w-1];
          ny = sgn && y[w-1];
          ux = nx ? ((64'd0 - x) & m) : x;
          uy = ny ? ((64'd0 - y) & m) : y;
          if (op == OP_MOD) begin
            o.res = ux % uy;
            if (nx) o.res = 64'd0 - o.res;
          end else begin
            o.res = ux / uy;
            if (nx != ny) o.res = 64'd0 - o.res;
          end
          o.res &= m;
        end
      end
      OP_SHL: begin
        if (y >= 64'(w)) begin
          o.res = '0;
          if (x != 0) o.st = ST_OVER;
        end else begin
          o.res = (x << y) & m;
          if ((o.res >> y) != x) o.st = ST_OVER;
        end
      end
      OP_SHR: begin
        if (y >= 64'(w)) begin
          o.res = '0;
          if (x != 0) o.st = ST_UNDER;
        end else begin
          o.res = x >> y;
          if ((o.res << y) != x) o.st = ST_UNDER;
        end
      end
      OP_AND: o.res = x & y;
      OP_XOR: o.res = x ^ y;
      OP_OR:  o.res = x | y;
      OP_NOT: o.res = ~x & m;
      OP_NEG: o.res = (64'd0 - x) & m;
      OP_CMP: begin
        a = x;
        b = y;
        if (sgn) begin
          sb = 64'd1 << (w - 1);
          a ^= sb;
          b ^= sb;
        end
        o.cmp = (a == b) ? CMP_EQ : ((a > b) ? CMP_GT : CMP_LT);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    alu_out_t p;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predicted_q.push_back(alu_predict(op_t'(s_tdata[3:0]), s_tdata[10:4], s_tdata[11],
                                          s_tdata[75:12], s_tdata[139:76]));
      if (m_tvalid && m_tready) begin
        result_count++;
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          p = predicted_q.pop_front();
          if (m_tdata[63:0] !== p.res)
            report_mismatch($sformatf("result %h, want %h", m_tdata[63:0], p.res));
          if (m_tdata[65:64] !== p.st)
            report_mismatch($sformatf("status %0d, want %0d", m_tdata[65:64], p.st));
          if (m_tdata[67:66] !== p.cmp)
            report_mismatch($sformatf("compare %0d, want %0d", m_tdata[67:66], p.cmp));
        end
      end
    end
    pending = predicted_q.size();
  end

endmodule

// ===== dv/tb_width_param_integer_alu_top.sv =====
`timescale 1ns / 100ps

module tb_width_param_integer_alu_top;
  import wpia_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  int           fail_count, pending, result_count;
  int           tx_idle_pct = 18;
  int           rx_idle_pct = 70;
  logic         hold_req = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_cnt = 0;
  int           sent = 0;

  always #2 clk = ~clk;

  width_param_integer_alu_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  wpia_result_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 400;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one input transaction, with random idle cycles in front
  task automatic send_op(op_t op, int unsigned w, logic sgn, logic [63:0] lhs,
                         logic [63:0] rhs);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, rhs, lhs, sgn, w[6:0], op};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  function automatic logic [63:0] wmask(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] pick_operand(int unsigned w);
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1;
      3: v = 64'd1 << (w - 1);
      4: v = wmask(w) >> 1;
      5: v = 64'($urandom_range(70));
      default: v = {$urandom, $urandom};
    endcase
    // mostly within width, sometimes stray upper bits
    return ($urandom_range(9) == 0) ? v : (v & wmask(w));
  endfunction

  task automatic send_random();
    int unsigned w;
    op_t         op;
    logic [63:0] rhs;
    op = op_t'($urandom_range(12));
    case ($urandom_range(4))
      0: w = 64;
      1: begin
        case ($urandom_range(7))
          0: w = 1; 1: w = 2; 2: w = 7; 3: w = 8;
          4: w = 16; 5: w = 31; 6: w = 32; default: w = 33;
        endcase
      end
      default: w = $urandom_range(64, 1);
    endcase
    rhs = pick_operand(w);
    if ((op == OP_SHL || op == OP_SHR) && $urandom_range(2) != 0)
      rhs = 64'($urandom_range(w + 1));
    send_op(op, w, 1'($urandom_range(1)), pick_operand(w), rhs);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, each corner
    send_op(OP_ADD, 64, 1'b0, '1, 64'd1);
    send_op(OP_ADD, 1, 1'b0, 64'd1, 64'd1);
    send_op(OP_SUB, 64, 1'b0, 64'd0, 64'd1);
    send_op(OP_SUB, 8, 1'b1, 64'h80, 64'h7f);
    send_op(OP_MUL, 64, 1'b0, '1, '1);
    send_op(OP_MUL, 32, 1'b0, 64'hffff, 64'h10001);
    send_op(OP_DIV, 64, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_op(OP_DIV, 16, 1'b1, 64'hfff9, 64'd2);
    send_op(OP_DIV, 64, 1'b0, '1, 64'd0);
    send_op(OP_MOD, 16, 1'b1, 64'hfff9, 64'd2);
    send_op(OP_MOD, 64, 1'b0, 64'd5, 64'd0);
    send_op(OP_SHL, 64, 1'b0, 64'd3, 64'd63);
    send_op(OP_SHL, 8, 1'b0, 64'd1, 64'd8);
    send_op(OP_SHR, 64, 1'b0, 64'd5, 64'd1);
    send_op(OP_SHR, 8, 1'b0, 64'h80, 64'd9);
    send_op(OP_AND, 64, 1'b0, '1, 64'h5555_aaaa_0f0f_f0f0);
    send_op(OP_XOR, 64, 1'b1, '1, 64'h1234_5678_9abc_def0);
    send_op(OP_OR, 7, 1'b0, 64'h41, 64'h3e);
    send_op(OP_NOT, 64, 1'b0, 64'd0, 64'd0);
    send_op(OP_NEG, 64, 1'b1, 64'h8000_0000_0000_0000, 64'd0);
    send_op(OP_CMP, 64, 1'b1, 64'h8000_0000_0000_0000, 64'd1);
    send_op(OP_CMP, 64, 1'b0, 64'h8000_0000_0000_0000, 64'd1);
    send_op(OP_CMP, 1, 1'b1, 64'd1, 64'd1);
    send_op(OP_CMP, 1, 1'b1, 64'd0, 64'd1);

    // random, sender light and receiver heavy idling
    repeat (500) send_random();

    // pause until the pipe drains, then fill it against a long hold-off
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    hold_req <= 1'b1;
    repeat (200) send_random();

    tx_idle_pct = 70;
    rx_idle_pct = 18;
    repeat (550) send_random();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (650) send_random();
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d transactions, all thirteen operations, widths 1 to 64,", sent);
    $display("idle and stall mixes both ways and a full-pipe hold-off; %0d results",
             result_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
